// ===== src/bilinear_grid_sample_top_assert.svh =====
// Assertion macros for the bilinear grid sampler.
// BGS_ASSERT_SAME checks the consequent in the cycle of the antecedent,
// BGS_ASSERT_NEXT checks it in the cycle after that.
`ifndef BILINEAR_GRID_SAMPLE_TOP_ASSERT_SVH
`define BILINEAR_GRID_SAMPLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define BGS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bilinear_grid_sample: assertion failed");
`define BGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bilinear_grid_sample: assertion failed");
`else
`define BGS_ASSERT_SAME(label, clk, rst, ante, cons)
`define BGS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/bgs_pkg.sv =====
package bgs_pkg;

   // Parameter defaults
   localparam int MAX_ROWS_DEFAULT   = 16;
   localparam int MAX_COLS_DEFAULT   = 16;
   localparam int FRAC_BITS_DEFAULT  = 8;
   localparam int BANK_DEPTH_DEFAULT = 64;

   // Fixed field widths
   localparam int POS_W       = 17;
   localparam int HEIGHT_W    = 16;
   localparam int GRID_IDX_W  = 4;
   localparam int SIZE_W      = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   localparam int MIN_SIZE = 2;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd2;

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COLUMNS_IN_USE = 2'd0,
      CSR_ROWS_IN_USE    = 2'd1,
      CSR_MESH_VALID     = 2'd2
   } csr_index_type;

endpackage

// ===== src/bgs_ram.sv =====
module bgs_ram #(
   parameter int WIDTH = bgs_pkg::HEIGHT_W,
   parameter int DEPTH = bgs_pkg::BANK_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
   end

   // Read-first; data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== src/bilinear_grid_sample_top.sv =====
// A sample request moves through stages 1 to 4 and then the output register.
// Throughput: one request (write or sample) per cycle while req_stall is low; the four
// grid banks each give one read per cycle, so the four corners of a cell come out in
// one access. Reset (synchronous, active high) clears the pipeline valids and mesh valid,
// sets both sizes to 2 and stalls requests while it is high; grid contents are
// undefined until written and get no clearing pass.
`include "bilinear_grid_sample_top_assert.svh"

module bilinear_grid_sample_top #(
   parameter int MAX_ROWS  = bgs_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLS  = bgs_pkg::MAX_COLS_DEFAULT,
   parameter int FRAC_BITS = bgs_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [bgs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bgs_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic [bgs_pkg::GRID_IDX_W-1:0]       req_write_row,
   input  logic [bgs_pkg::GRID_IDX_W-1:0]       req_write_col,
   input  logic signed [bgs_pkg::HEIGHT_W-1:0]  req_write_height,
   input  logic signed [bgs_pkg::POS_W-1:0]     req_sample_col_pos,
   input  logic signed [bgs_pkg::POS_W-1:0]     req_sample_row_pos,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [bgs_pkg::HEIGHT_W-1:0]  rsp_sampled_height
);

   import bgs_pkg::*;

   // Index widths of the full grid and of one parity bank.
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ROW_HALF_W = ($clog2((MAX_ROWS + 1) / 2) > 0) ? $clog2((MAX_ROWS + 1) / 2) : 1;
   localparam int COL_HALF_W = ($clog2((MAX_COLS + 1) / 2) > 0) ? $clog2((MAX_COLS + 1) / 2) : 1;
   localparam int BANK_AW    = ROW_HALF_W + COL_HALF_W;
   localparam int BANK_DEPTH = 2 ** BANK_AW;
   localparam int NUM_BANKS  = 4;

   // Width that holds the saturated grid size.
   localparam int MAX_DIM   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int SZ_W      = ($clog2(MAX_DIM + 1) > SIZE_W) ? $clog2(MAX_DIM + 1) : SIZE_W;

   // Position magnitude and clamp compare widths.
   localparam int MAG_W     = POS_W - 1;
   localparam int TOP_W     = SZ_W + FRAC_BITS;
   localparam int CMP_W     = (TOP_W > MAG_W) ? TOP_W : MAG_W;

   // Blend arithmetic widths.
   localparam int DIFF_W    = HEIGHT_W + 1;
   localparam int PROD_W    = DIFF_W + FRAC_BITS + 1;

   //------------------------------------------------------------------
   // Configuration registers
   //------------------------------------------------------------------
   logic [SIZE_W-1:0] cols_ff;
   logic [SIZE_W-1:0] rows_ff;
   logic              mesh_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff       <= SIZE_RESET;
         rows_ff       <= SIZE_RESET;
         mesh_valid_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_COLUMNS_IN_USE: begin
               cols_ff <= csr_write_data[SIZE_W-1:0];
            end
            CSR_ROWS_IN_USE: begin
               rows_ff <= csr_write_data[SIZE_W-1:0];
            end
            CSR_MESH_VALID: begin
               mesh_valid_ff <= csr_write_data[0];
            end
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   // Saturate the sizes in use to MIN_SIZE..MAX.
   logic [SZ_W-1:0] ncols;
   logic [SZ_W-1:0] nrows;

   always_comb begin
      if (SZ_W'(cols_ff) < SZ_W'(MIN_SIZE)) begin
         ncols = SZ_W'(MIN_SIZE);
      end else if (SZ_W'(cols_ff) > SZ_W'(MAX_COLS)) begin
         ncols = SZ_W'(MAX_COLS);
      end else begin
         ncols = SZ_W'(cols_ff);
      end
      if (SZ_W'(rows_ff) < SZ_W'(MIN_SIZE)) begin
         nrows = SZ_W'(MIN_SIZE);
      end else if (SZ_W'(rows_ff) > SZ_W'(MAX_ROWS)) begin
         nrows = SZ_W'(MAX_ROWS);
      end else begin
         nrows = SZ_W'(rows_ff);
      end
   end

   //------------------------------------------------------------------
   // Pipeline handshake: each stage advances when the next one is free
   // or moving, so a finished result waiting in the output register
   // does not block new requests until the pipe is full.
   //------------------------------------------------------------------
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic s4_valid_ff;
   logic rsp_valid_ff;

   logic out_ready;
   logic s4_ready;
   logic s3_ready;
   logic s2_ready;
   logic s1_ready;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s4_ready  = !s4_valid_ff || out_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   // Hold off requests while reset is high.
   assign req_stall = !s1_ready || reset;

   logic req_take;
   logic sample_take;
   logic write_take;

   assign req_take    = req_valid && !req_stall;
   assign sample_take = req_take && (req_mode == MODE_SAMPLE);
   // Ignore writes outside the grid size in use.
   assign write_take  = req_take && (req_mode == MODE_WRITE)
                        && (SZ_W'(req_write_row) < nrows)
                        && (SZ_W'(req_write_col) < ncols);

   //------------------------------------------------------------------
   // Stage 0: clamp positions, split into cell index and fraction,
   // issue the four corner reads.
   //------------------------------------------------------------------
   function automatic logic [MAG_W-1:0] clamp_pos(input logic signed [POS_W-1:0] pos,
                                                  input logic [SZ_W-1:0] n);
      logic [CMP_W-1:0] top;
      logic [CMP_W-1:0] mag;
      top = CMP_W'(n - SZ_W'(1)) << FRAC_BITS;
      mag = CMP_W'(pos[MAG_W-1:0]);
      if (pos[POS_W-1]) begin
         clamp_pos = '0;
      end else if (mag > top) begin
         clamp_pos = MAG_W'(top);
      end else begin
         clamp_pos = pos[MAG_W-1:0];
      end
   endfunction

   logic [MAG_W-1:0]     col_clamped;
   logic [MAG_W-1:0]     row_clamped;
   logic [COL_W-1:0]     c0;
   logic [COL_W-1:0]     c0_next;
   logic [ROW_W-1:0]     r0;
   logic [ROW_W-1:0]     r0_next;
   logic [FRAC_BITS-1:0] fs;
   logic [FRAC_BITS-1:0] ft;

   assign col_clamped = clamp_pos(req_sample_col_pos, ncols);
   assign row_clamped = clamp_pos(req_sample_row_pos, nrows);
   assign c0          = COL_W'(col_clamped >> FRAC_BITS);
   assign r0          = ROW_W'(row_clamped >> FRAC_BITS);
   assign fs          = col_clamped[FRAC_BITS-1:0];
   assign ft          = row_clamped[FRAC_BITS-1:0];
   // The neighbor only matters when the fraction is nonzero, and then it
   // is inside the grid, so a plain increment serves for the clamped one.
   // A zero fraction forces the blend product to zero, so a neighbor past
   // the last column or row never reaches the result.
   assign c0_next     = c0 + COL_W'(1);
   assign r0_next     = r0 + ROW_W'(1);

   // Grid banks split by row and column parity: the four corners of any
   // cell land in four different banks.
   logic [NUM_BANKS-1:0]    bank_we;
   logic [BANK_AW-1:0]      bank_waddr;
   logic [BANK_AW-1:0]      bank_raddr [NUM_BANKS];
   logic [HEIGHT_W-1:0]     bank_rdata [NUM_BANKS];

   assign bank_waddr = {ROW_HALF_W'(req_write_row >> 1), COL_HALF_W'(req_write_col >> 1)};

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      localparam int BANK_ROW_PAR = b / 2;
      localparam int BANK_COL_PAR = b % 2;

      logic [ROW_W-1:0] rsel;
      logic [COL_W-1:0] csel;

      assign bank_we[b] = write_take
                          && (req_write_row[0] == 1'(BANK_ROW_PAR))
                          && (req_write_col[0] == 1'(BANK_COL_PAR));

      assign rsel = (r0[0] == 1'(BANK_ROW_PAR)) ? r0 : r0_next;
      assign csel = (c0[0] == 1'(BANK_COL_PAR)) ? c0 : c0_next;
      assign bank_raddr[b] = {ROW_HALF_W'(rsel >> 1), COL_HALF_W'(csel >> 1)};

      bgs_ram #(
         .WIDTH (HEIGHT_W),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock        (clock),
         .write_enable (bank_we[b]),
         .write_addr   (bank_waddr),
         .write_data   (req_write_height),
         .read_enable  (sample_take),
         .read_addr    (bank_raddr[b]),
         .read_data    (bank_rdata[b])
      );
   end

   //------------------------------------------------------------------
   // Stage 1: corner data sits in the bank output registers.
   //------------------------------------------------------------------
   logic [FRAC_BITS-1:0] s1_fs_ff;
   logic [FRAC_BITS-1:0] s1_ft_ff;
   logic                 s1_zero_ff;
   logic                 s1_row_par_ff;
   logic                 s1_col_par_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= sample_take;
      end
   end

   always_ff @(posedge clock) begin
      if (sample_take) begin
         s1_fs_ff      <= fs;
         s1_ft_ff      <= ft;
         s1_zero_ff    <= !mesh_valid_ff;
         s1_row_par_ff <= r0[0];
         s1_col_par_ff <= c0[0];
      end
   end

   // Route banks back to corners: a=(r0,c0) b=(r0,c1) c=(r1,c0) d=(r1,c1).
   logic signed [HEIGHT_W-1:0] corner_a;
   logic signed [HEIGHT_W-1:0] corner_b;
   logic signed [HEIGHT_W-1:0] corner_c;
   logic signed [HEIGHT_W-1:0] corner_d;

   always_comb begin
      unique case ({s1_row_par_ff, s1_col_par_ff})
         2'b00: begin
            corner_a = bank_rdata[0];
            corner_b = bank_rdata[1];
            corner_c = bank_rdata[2];
            corner_d = bank_rdata[3];
         end
         2'b01: begin
            corner_a = bank_rdata[1];
            corner_b = bank_rdata[0];
            corner_c = bank_rdata[3];
            corner_d = bank_rdata[2];
         end
         2'b10: begin
            corner_a = bank_rdata[2];
            corner_b = bank_rdata[3];
            corner_c = bank_rdata[0];
            corner_d = bank_rdata[1];
         end
         2'b11: begin
            corner_a = bank_rdata[3];
            corner_b = bank_rdata[2];
            corner_c = bank_rdata[1];
            corner_d = bank_rdata[0];
         end
      endcase
   end

   // Horizontal blend products for both rows.
   logic signed [DIFF_W-1:0] row0_diff;
   logic signed [DIFF_W-1:0] row1_diff;
   logic signed [PROD_W-1:0] prod0_in;
   logic signed [PROD_W-1:0] prod1_in;

   assign row0_diff = $signed({corner_b[HEIGHT_W-1], corner_b})
                      - $signed({corner_a[HEIGHT_W-1], corner_a});
   assign row1_diff = $signed({corner_d[HEIGHT_W-1], corner_d})
                      - $signed({corner_c[HEIGHT_W-1], corner_c});
   assign prod0_in  = (s1_fs_ff == '0) ? $signed(PROD_W'(0))
                                       : row0_diff * $signed({1'b0, s1_fs_ff});
   assign prod1_in  = (s1_fs_ff == '0) ? $signed(PROD_W'(0))
                                       : row1_diff * $signed({1'b0, s1_fs_ff});

   //------------------------------------------------------------------
   // Stage 2: horizontal products registered.
   //------------------------------------------------------------------
   logic signed [PROD_W-1:0]   s2_prod0_ff;
   logic signed [PROD_W-1:0]   s2_prod1_ff;
   logic signed [HEIGHT_W-1:0] s2_base0_ff;
   logic signed [HEIGHT_W-1:0] s2_base1_ff;
   logic [FRAC_BITS-1:0]       s2_ft_ff;
   logic                       s2_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         s2_prod0_ff <= prod0_in;
         s2_prod1_ff <= prod1_in;
         s2_base0_ff <= corner_a;
         s2_base1_ff <= corner_c;
         s2_ft_ff    <= s1_ft_ff;
         s2_zero_ff  <= s1_zero_ff;
      end
   end

   // Floor shift is an arithmetic right shift; the sum stays within the
   // two corner heights, so it fits the height width.
   logic signed [HEIGHT_W-1:0] zi0_in;
   logic signed [HEIGHT_W-1:0] zi1_in;

   assign zi0_in = s2_base0_ff + HEIGHT_W'(s2_prod0_ff >>> FRAC_BITS);
   assign zi1_in = s2_base1_ff + HEIGHT_W'(s2_prod1_ff >>> FRAC_BITS);

   //------------------------------------------------------------------
   // Stage 3: row blends registered.
   //------------------------------------------------------------------
   logic signed [HEIGHT_W-1:0] s3_zi0_ff;
   logic signed [HEIGHT_W-1:0] s3_zi1_ff;
   logic [FRAC_BITS-1:0]       s3_ft_ff;
   logic                       s3_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s3_ready) begin
         s3_zi0_ff  <= zi0_in;
         s3_zi1_ff  <= zi1_in;
         s3_ft_ff   <= s2_ft_ff;
         s3_zero_ff <= s2_zero_ff;
      end
   end

   logic signed [DIFF_W-1:0] col_diff;
   logic signed [PROD_W-1:0] vprod_in;

   assign col_diff = $signed({s3_zi1_ff[HEIGHT_W-1], s3_zi1_ff})
                     - $signed({s3_zi0_ff[HEIGHT_W-1], s3_zi0_ff});
   assign vprod_in = (s3_ft_ff == '0) ? $signed(PROD_W'(0))
                                      : col_diff * $signed({1'b0, s3_ft_ff});

   //------------------------------------------------------------------
   // Stage 4: vertical product registered.
   //------------------------------------------------------------------
   logic signed [PROD_W-1:0]   s4_prod_ff;
   logic signed [HEIGHT_W-1:0] s4_base_ff;
   logic                       s4_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff && s4_ready) begin
         s4_prod_ff <= vprod_in;
         s4_base_ff <= s3_zi0_ff;
         s4_zero_ff <= s3_zero_ff;
      end
   end

   // Force zero when no mesh is loaded.
   logic signed [HEIGHT_W-1:0] z_in;

   assign z_in = s4_zero_ff ? '0 : s4_base_ff + HEIGHT_W'(s4_prod_ff >>> FRAC_BITS);

   //------------------------------------------------------------------
   // Output register: hold the result while the consumer stalls.
   //------------------------------------------------------------------
   logic signed [HEIGHT_W-1:0] rsp_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_valid_ff && out_ready) begin
         rsp_height_ff <= z_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sampled_height = rsp_height_ff;

   //------------------------------------------------------------------
   // Assertions
   //------------------------------------------------------------------
   // At most one bank takes a write per cycle.
   `BGS_ASSERT_SAME(a_bank_write_onehot, clock, reset, 1'b1, $onehot0(bank_we))
   // A stalled first stage keeps its corner data in the bank outputs.
   `BGS_ASSERT_NEXT(a_corner_hold, clock, reset, s1_valid_ff && !s2_ready, s1_valid_ff && $stable(corner_a) && $stable(corner_d))
   // A cell on the last column has no fraction left.
   `BGS_ASSERT_SAME(a_last_col_no_frac, clock, reset, sample_take && (SZ_W'(c0) == ncols - SZ_W'(1)), fs == '0)
   // A sample taken without a mesh comes out as zero.
   `BGS_ASSERT_NEXT(a_no_mesh_zero, clock, reset, s4_valid_ff && s4_zero_ff && out_ready, rsp_valid_ff && (rsp_height_ff == '0))

endmodule

// ===== dv/tb_bilinear_grid_sample_top.sv =====
module tb_bilinear_grid_sample_top;
   import bgs_pkg::*;

   localparam int GRID_ROWS       = MAX_ROWS_DEFAULT;
   localparam int GRID_COLS       = MAX_COLS_DEFAULT;
   localparam int FRAC            = FRAC_BITS_DEFAULT;
   localparam int LATENCY         = 4;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int PHASE_COUNT     = 10;
   localparam int PHASE_REQUESTS  = 30;

   // Predict the sampled height of each accepted request and check the results in order.
   class grid_sample_scoreboard;
      logic signed [HEIGHT_W-1:0] grid [GRID_ROWS*GRID_COLS];
      logic [SIZE_W-1:0]          cols_reg;
      logic [SIZE_W-1:0]          rows_reg;
      logic                       mesh_reg;
      logic signed [HEIGHT_W-1:0] expected_heights [$];
      int                         mismatches;

      function new();
         foreach (grid[i]) grid[i] = '0;
         cols_reg   = SIZE_RESET;
         rows_reg   = SIZE_RESET;
         mesh_reg   = 1'b0;
         mismatches = 0;
      endfunction

      function void write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_COLUMNS_IN_USE: cols_reg = data;
            CSR_ROWS_IN_USE:    rows_reg = data;
            CSR_MESH_VALID:     mesh_reg = data[0];
            default: ;
         endcase
      endfunction

      function int effective_size(logic [SIZE_W-1:0] v, int max_size);
         if (v < MIN_SIZE) return MIN_SIZE;
         if (v > max_size) return max_size;
         return v;
      endfunction

      function int columns_used();
         return effective_size(cols_reg, GRID_COLS);
      endfunction

      function int rows_used();
         return effective_size(rows_reg, GRID_ROWS);
      endfunction

      function void split_position(logic signed [POS_W-1:0] pos, int n,
                                   output int lo, output int hi, output int frac);
         int p;
         int top;
         p   = pos;
         top = (n - 1) << FRAC;
         if (p < 0) p = 0;
         if (p > top) p = top;
         lo   = p >> FRAC;
         frac = p & ((1 << FRAC) - 1);
         hi   = (lo + 1 < n) ? lo + 1 : n - 1;
      endfunction

      function int blend(int a, int b, int f);
         return a + ((f * (b - a)) >>> FRAC);
      endfunction

      function void note_request(logic mode, logic [GRID_IDX_W-1:0] row,
                                 logic [GRID_IDX_W-1:0] col,
                                 logic signed [HEIGHT_W-1:0] height,
                                 logic signed [POS_W-1:0] col_pos,
                                 logic signed [POS_W-1:0] row_pos);
         int nc, nr, c0, c1, r0, r1, fc, fr, upper, lower, z;
         nc = columns_used();
         nr = rows_used();
         if (mode == MODE_WRITE) begin
            if (row < nr && col < nc) grid[row*GRID_COLS + col] = height;
            return;
         end
         if (!mesh_reg) begin
            expected_heights = {expected_heights, HEIGHT_W'(0)};
            return;
         end
         split_position(col_pos, nc, c0, c1, fc);
         split_position(row_pos, nr, r0, r1, fr);
         upper = blend(grid[r0*GRID_COLS + c0], grid[r0*GRID_COLS + c1], fc);
         lower = blend(grid[r1*GRID_COLS + c0], grid[r1*GRID_COLS + c1], fc);
         z     = blend(upper, lower, fr);
         expected_heights = {expected_heights, HEIGHT_W'(z)};
      endfunction

      function void check_height(logic signed [HEIGHT_W-1:0] got);
         logic signed [HEIGHT_W-1:0] want;
         if (expected_heights.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected sampled height %0d with nothing expected", $time, got);
            return;
         end
         want = expected_heights.pop_front();
         if (got !== want) begin
            mismatches++;
            $display("%0t: sampled height mismatch: expected %0d actual %0d",
                     $time, want, got);
         end
      endfunction

      function int pending();
         return expected_heights.size();
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         csr_write_enable;
   logic [CSR_INDEX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]        csr_write_data;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_mode;
   logic [GRID_IDX_W-1:0]        req_write_row;
   logic [GRID_IDX_W-1:0]        req_write_col;
   logic signed [HEIGHT_W-1:0]   req_write_height;
   logic signed [POS_W-1:0]      req_sample_col_pos;
   logic signed [POS_W-1:0]      req_sample_row_pos;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [HEIGHT_W-1:0]   rsp_sampled_height;

   grid_sample_scoreboard grid_sb;

   // Idling odds in percent, set per phase by the main sequence.
   int   sender_idle_pct;
   int   receiver_stall_pct;
   logic hold_off_go;

   // Size and mesh settings swept by the random phases; out-of-range sizes saturate,
   // and a mesh write of 2 keeps only bit 0, so that phase samples with mesh off.
   int phase_cols [PHASE_COUNT] = '{16, 2, 0, 5, 31, 3, 16, 7, 12, 16};
   int phase_rows [PHASE_COUNT] = '{16, 2, 1, 9, 17, 16, 2, 4, 13, 16};
   int phase_mesh [PHASE_COUNT] = '{1, 1, 1, 1, 1, 1, 1, 2, 1, 1};

   bilinear_grid_sample_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_write_row      (req_write_row),
      .req_write_col      (req_write_col),
      .req_write_height   (req_write_height),
      .req_sample_col_pos (req_sample_col_pos),
      .req_sample_row_pos (req_sample_row_pos),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sampled_height (rsp_sampled_height)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Note every request at the edge that accepts it; the predictor runs in that order.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         grid_sb.note_request(req_mode, req_write_row, req_write_col, req_write_height,
                              req_sample_col_pos, req_sample_row_pos);
   end

   // Check every result at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         grid_sb.check_height(rsp_sampled_height);
   end

   // Drive the result stall at falling edges. On request, hold it high for a long
   // stretch so the pipeline fills and pushes back on the request side.
   initial begin : receiver
      int n;
      forever begin
         @(negedge clock);
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            for (n = 0; n < HOLD_OFF_CYCLES; n++) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // End the run if it hangs, e.g. on a result that never comes.
   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // Offer one request, after a random gap when idling is on, and hold it until it is taken.
   task automatic send_request(logic mode, logic [GRID_IDX_W-1:0] row,
                               logic [GRID_IDX_W-1:0] col,
                               logic signed [HEIGHT_W-1:0] height,
                               logic signed [POS_W-1:0] col_pos,
                               logic signed [POS_W-1:0] row_pos);
      @(negedge clock);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= mode;
      req_write_row      <= row;
      req_write_col      <= col;
      req_write_height   <= height;
      req_sample_col_pos <= col_pos;
      req_sample_row_pos <= row_pos;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every expected height has come, then let the last
   // write, which gives no result, leave the pipeline.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (grid_sb.pending() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      grid_sb.write_csr(idx, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_grid_config(int cols, int rows, int mesh);
      wait_idle();
      csr_write(CSR_COLUMNS_IN_USE, CSR_DATA_W'(cols));
      csr_write(CSR_ROWS_IN_USE, CSR_DATA_W'(rows));
      csr_write(CSR_MESH_VALID, CSR_DATA_W'(mesh));
   endtask

   // Pick a position along an axis of n samples: mostly inside the grid, with
   // negative, exact-edge, past-the-edge and fully random values mixed in.
   function automatic logic signed [POS_W-1:0] pick_position(int n);
      int top;
      top = (n - 1) << FRAC;
      case ($urandom_range(9))
         0: return POS_W'($urandom);
         1: return POS_W'(-int'($urandom_range(1, 2000)));
         2: return POS_W'(top);
         3: return POS_W'(top + int'($urandom_range(1, 3000)));
         default: return POS_W'($urandom_range(0, top + 255));
      endcase
   endfunction

   initial begin : main
      int r, c, p, k, nc, nr;
      logic signed [HEIGHT_W-1:0] h;
      logic [GRID_IDX_W-1:0] row, col;

      grid_sb            = new();
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_COLUMNS_IN_USE;
      csr_write_data     = '0;
      req_valid          = 1'b0;
      req_mode           = MODE_WRITE;
      req_write_row      = '0;
      req_write_col      = '0;
      req_write_height   = '0;
      req_sample_col_pos = '0;
      req_sample_row_pos = '0;
      rsp_stall          = 1'b0;
      hold_off_go        = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Open the full grid (rows given as 31 to hit saturation) with the mesh still
      // off, then load every entry so no later sample reads an unwritten one.
      set_grid_config(16, 31, 0);
      for (r = 0; r < GRID_ROWS; r++) begin
         for (c = 0; c < GRID_COLS; c++) begin
            h = HEIGHT_W'($urandom);
            // Put opposite extremes on the first cell for worst-case blends.
            if (r < 2 && c < 2) h = (r == c) ? 16'sh8000 : 16'sh7fff;
            send_request(MODE_WRITE, GRID_IDX_W'(r), GRID_IDX_W'(c), h,
                         POS_W'($urandom), POS_W'($urandom));
         end
      end

      // Mesh off: every sample returns zero.
      send_request(MODE_SAMPLE, '0, '0, '0, 17'sd65535, 17'sd65535);
      send_request(MODE_SAMPLE, '1, '1, '1, 17'sh10000, 17'sd300);

      set_grid_config(16, 16, 1);
      send_request(MODE_SAMPLE, '0, '0, '0, 17'sd0, 17'sd0);
      send_request(MODE_SAMPLE, '0, '0, '0, 17'sh10000, 17'sh10000);
      send_request(MODE_SAMPLE, '0, '0, '0, 17'sd65535, 17'sd65535);
      send_request(MODE_SAMPLE, '0, '0, '0, 17'sd255, 17'sd255);
      send_request(MODE_SAMPLE, '0, '0, '0, 17'sd3840, 17'sd3840);
      send_request(MODE_SAMPLE, '0, '0, '0, 17'sd3968, 17'sd1);
      send_request(MODE_SAMPLE, '0, '0, '0, 17'sd128, -17'sd1);
      // Sample right behind a write to the same cell.
      send_request(MODE_WRITE, 4'd5, 4'd7, 16'sh7fff, '0, '0);
      send_request(MODE_WRITE, 4'd5, 4'd8, 16'sh8000, '0, '0);
      send_request(MODE_SAMPLE, '0, '0, '0, 17'sd1920, 17'sd1280);
      send_request(MODE_WRITE, 4'd15, 4'd15, 16'sh1234, '0, '0);
      send_request(MODE_SAMPLE, '0, '0, '0, 17'sd3840, 17'sd3840);

      // Writes outside a 3x3 grid are dropped; widen to 4x4 and read the old values.
      set_grid_config(3, 3, 1);
      send_request(MODE_WRITE, 4'd0, 4'd3, 16'sh5a5a, '0, '0);
      send_request(MODE_WRITE, 4'd3, 4'd0, 16'sh5a5a, '0, '0);
      send_request(MODE_SAMPLE, '0, '0, '0, 17'sd65535, 17'sd0);
      set_grid_config(4, 4, 1);
      send_request(MODE_SAMPLE, '0, '0, '0, 17'sd768, 17'sd0);
      send_request(MODE_SAMPLE, '0, '0, '0, 17'sd0, 17'sd768);

      // Random phases: sweep sizes and rotate the idling pattern.
      for (p = 0; p < PHASE_COUNT; p++) begin
         set_grid_config(phase_cols[p], phase_rows[p], phase_mesh[p]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 71; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 71; end
            default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
         endcase
         nc = grid_sb.columns_used();
         nr = grid_sb.rows_used();
         for (k = 0; k < PHASE_REQUESTS; k++) begin
            row = GRID_IDX_W'($urandom);
            col = GRID_IDX_W'($urandom);
            h   = HEIGHT_W'($urandom);
            if ($urandom_range(99) < 35) begin
               // Keep most writes inside the grid; the rest take random indexes and are dropped when outside it.
               if ($urandom_range(3) != 0) begin
                  row = GRID_IDX_W'($urandom_range(nr - 1));
                  col = GRID_IDX_W'($urandom_range(nc - 1));
               end
               case ($urandom_range(7))
                  0: h = 16'sh7fff;
                  1: h = 16'sh8000;
                  default: ;
               endcase
               send_request(MODE_WRITE, row, col, h, POS_W'($urandom), POS_W'($urandom));
            end else begin
               send_request(MODE_SAMPLE, row, col, h, pick_position(nc), pick_position(nr));
            end
         end
      end

      // Back-pressure: hold off results while samples keep coming at full rate.
      set_grid_config(16, 16, 1);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_go        = 1'b1;
      for (k = 0; k < 40; k++)
         send_request(MODE_SAMPLE, GRID_IDX_W'($urandom), GRID_IDX_W'($urandom),
                      HEIGHT_W'($urandom),
                      pick_position(GRID_COLS), pick_position(GRID_ROWS));

      wait_idle();
      if (grid_sb.mismatches == 0 && grid_sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/bgs_pkg.sv
src/bgs_ram.sv
src/bilinear_grid_sample_top.sv
dv/tb_bilinear_grid_sample_top.sv
